// ----- src/sfp_pkg.sv -----
// Shared types and constants of the SPI FIFO transfer pump.
`timescale 1ns / 1ps
package sfp_pkg;
	localparam int MAX_FRAMES     = 256;
	localparam int MAX_FIFO_DEPTH = 16;

	localparam int CNT_W   = 9;
	localparam int DEP_W   = 5;
	localparam int LVL_W   = 6;
	localparam int IDX_W   = 8;
	localparam int DATA_W  = 8;
	localparam int STORE_D = 256;
	localparam int CFG_AW  = 2;
	localparam int CFG_DW  = 9;

	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_LOAD    = 2'd1,
		CMD_SERVICE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_POP     = 2'd0,
		KIND_PUSH    = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DEV_ERR = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	typedef enum logic [CFG_AW-1:0] {
		REG_TRANSFER_LENGTH = 2'd0,
		REG_FIFO_DEPTH      = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] frames;
		logic [DEP_W-1:0] depth;
	} cfg_t;

	typedef struct packed {
		kind_t             kind;
		logic [IDX_W-1:0]  buffer_index;
		logic [DATA_W-1:0] tx_byte;
		status_t           status;
		logic              enable_error_irq;
		logic              enable_rx_irq;
		logic              enable_tx_irq;
		logic              done_res;
		logic              last;
	} res_t;
endpackage

// ----- src/sfp_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module sfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// ----- src/sfp_seq.sv -----
// Command decode, frame counters and pop/push/summary sequencer over the transmit store.
`timescale 1ns / 1ps
module sfp_seq import sfp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        cmd,
	input  logic [DATA_W-1:0] tx_data,
	input  logic              error_raised,
	input  logic [LVL_W-1:0]  rx_level,
	input  logic [LVL_W-1:0]  tx_level,
	input  logic              busy_req,
	input  cfg_t              cfg,
	input  logic              free,
	output logic              emit,
	output res_t              res
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_POP,
		S_CREDIT,
		S_PUSH_RD,
		S_PUSH,
		S_SUM
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  sent_q;
	logic [CNT_W-1:0]  recv_q;
	logic [IDX_W-1:0]  load_q;
	logic              err_q;
	logic              busy_q;
	logic [LVL_W-1:0]  rx_q;
	logic [LVL_W-1:0]  tx_q;
	logic [DEP_W-1:0]  cnt_q;
	status_t           sum_status_q;
	logic              sum_done_q;
	logic              sum_norm_q;

	logic              accept;
	logic [CNT_W-1:0]  inflight;
	logic [CNT_W-1:0]  dep9;
	logic              rx_bad;
	logic              tx_bad;
	logic [DEP_W-1:0]  avail;
	logic [DEP_W-1:0]  credit;
	logic [DEP_W-1:0]  room;
	logic [CNT_W-1:0]  remain;
	logic [DEP_W-1:0]  push_n;
	logic              tx_more;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [DATA_W-1:0] rd_data;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	assign inflight = (sent_q >= recv_q) ? (sent_q - recv_q) : '0;
	assign dep9     = CNT_W'(cfg.depth);
	assign rx_bad   = (CNT_W'(rx_q) > dep9) || (CNT_W'(rx_q) > inflight);
	assign tx_bad   = CNT_W'(tx_q) > dep9;
	assign avail    = cfg.depth - DEP_W'(tx_q);
	assign credit   = (dep9 > inflight) ? DEP_W'(dep9 - inflight) : '0;
	assign room     = (avail < credit) ? avail : credit;
	assign remain   = (cfg.frames > sent_q) ? (cfg.frames - sent_q) : '0;
	assign push_n   = (CNT_W'(room) < remain) ? room : DEP_W'(remain);
	assign tx_more  = (sent_q < cfg.frames) && (inflight < dep9);

	assign rd_en   = (state_q == S_PUSH_RD) ||
	                 ((state_q == S_PUSH) && free && (cnt_q > DEP_W'(1)));
	assign rd_addr = (state_q == S_PUSH) ? (sent_q[IDX_W-1:0] + IDX_W'(1))
	                                     : sent_q[IDX_W-1:0];

	sfp_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STORE_D)
	) u_store (
		.clk    (clk),
		.wr_en  (accept && (cmd == CMD_LOAD)),
		.wr_addr(load_q),
		.wr_data(tx_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		emit = 1'b0;
		res  = '0;
		case (state_q)
			S_POP: begin
				emit             = free;
				res.kind         = KIND_POP;
				res.buffer_index = recv_q[IDX_W-1:0];
			end
			S_PUSH: begin
				emit             = free;
				res.kind         = KIND_PUSH;
				res.buffer_index = sent_q[IDX_W-1:0];
				res.tx_byte      = rd_data;
			end
			S_SUM: begin
				emit                 = free;
				res.kind             = KIND_SUMMARY;
				res.status           = sum_status_q;
				res.enable_error_irq = sum_norm_q;
				res.enable_rx_irq    = sum_norm_q;
				res.enable_tx_irq    = sum_norm_q && tx_more;
				res.done_res         = sum_done_q;
				res.last             = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sent_q       <= '0;
			recv_q       <= '0;
			load_q       <= '0;
			err_q        <= 1'b0;
			busy_q       <= 1'b0;
			rx_q         <= '0;
			tx_q         <= '0;
			cnt_q        <= '0;
			sum_status_q <= ST_OK;
			sum_done_q   <= 1'b0;
			sum_norm_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_START: begin
								sent_q <= '0;
								recv_q <= '0;
								load_q <= '0;
							end
							CMD_LOAD: begin
								load_q <= load_q + IDX_W'(1);
							end
							CMD_SERVICE: begin
								err_q   <= error_raised;
								busy_q  <= busy_req;
								rx_q    <= rx_level;
								tx_q    <= tx_level;
								state_q <= S_CHECK;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_CHECK: begin
					sum_norm_q <= 1'b0;
					sum_done_q <= 1'b0;
					if (err_q) begin
						sum_status_q <= ST_DEV_ERR;
						state_q      <= S_SUM;
					end else if (rx_bad) begin
						sum_status_q <= ST_RANGE;
						state_q      <= S_SUM;
					end else if (rx_q != '0) begin
						cnt_q   <= DEP_W'(rx_q);
						state_q <= S_POP;
					end else begin
						state_q <= S_CREDIT;
					end
				end
				S_POP: begin
					if (free) begin
						recv_q <= recv_q + CNT_W'(1);
						cnt_q  <= cnt_q - DEP_W'(1);
						if (cnt_q == DEP_W'(1)) begin
							state_q <= S_CREDIT;
						end
					end
				end
				S_CREDIT: begin
					if (recv_q == cfg.frames) begin
						sum_status_q <= ST_OK;
						sum_done_q   <= !busy_q;
						state_q      <= S_SUM;
					end else if (tx_bad) begin
						sum_status_q <= ST_RANGE;
						state_q      <= S_SUM;
					end else begin
						sum_status_q <= ST_OK;
						sum_norm_q   <= 1'b1;
						cnt_q        <= push_n;
						state_q      <= (push_n != '0) ? S_PUSH_RD : S_SUM;
					end
				end
				S_PUSH_RD: begin
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (free) begin
						sent_q <= sent_q + CNT_W'(1);
						cnt_q  <= cnt_q - DEP_W'(1);
						if (cnt_q == DEP_W'(1)) begin
							state_q <= S_SUM;
						end
					end
				end
				S_SUM: begin
					if (free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> free) else $error("result issued while output slot full");
	a_pop_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> (cnt_q != '0)) else $error("pop with zero count");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUSH) |-> ((cnt_q != '0) && (sent_q < cfg.frames)))
		else $error("push beyond transfer or with zero count");
	a_sum_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && res.last) |=> (state_q == S_IDLE))
		else $error("summary did not end the event");
`endif
endmodule

// ----- src/spi_fifo_transfer_pump.sv -----
// Top level: configuration registers, output register and sequencer.
//
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------
// input    | in_valid / in_stall   | cmd, tx_data, error_raised, rx_level,
//          |                       | tx_level, busy_req
// output   | out_valid / out_stall | kind, buffer_index, tx_byte, status,
//          |                       | enable_*_irq, done_res, last
// config   | cfg_we                | cfg_addr, cfg_wdata
//
// A service event runs check, then as needed pops, credit, a store read before
// pushes, pushes and a summary; one result per cycle leaves the sequencer into
// the output register while the output is not stalled. The store read port sets
// the push rate. Reset clears counters and the transfer length and sets the
// FIFO depth to 16; store contents stay undefined until loaded. A stalled output
// holds the sequencer; input is stalled until the event's summary is issued.
`timescale 1ns / 1ps
module spi_fifo_transfer_pump import sfp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        cmd,
	input  logic [DATA_W-1:0] tx_data,
	input  logic              error_raised,
	input  logic [LVL_W-1:0]  rx_level,
	input  logic [LVL_W-1:0]  tx_level,
	input  logic              busy_req,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        kind,
	output logic [IDX_W-1:0]  buffer_index,
	output logic [DATA_W-1:0] tx_byte,
	output logic [1:0]        status,
	output logic              enable_error_irq,
	output logic              enable_rx_irq,
	output logic              enable_tx_irq,
	output logic              done_res,
	output logic              last,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata
);
	logic [CNT_W-1:0] len_q;
	logic [DEP_W-1:0] depth_q;
	logic             out_valid_q;
	res_t             res_q;
	cfg_t             cfg;
	logic             free;
	logic             emit;
	res_t             res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			depth_q <= DEP_W'(MAX_FIFO_DEPTH);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TRANSFER_LENGTH: len_q   <= cfg_wdata[CNT_W-1:0];
				REG_FIFO_DEPTH:      depth_q <= cfg_wdata[DEP_W-1:0];
				default:             len_q   <= len_q;
			endcase
		end
	end

	assign cfg.frames = (int'(len_q) > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) : len_q;
	assign cfg.depth  = (int'(depth_q) > MAX_FIFO_DEPTH) ? DEP_W'(MAX_FIFO_DEPTH)
	                                                     : depth_q;

	assign free = !out_valid_q || !out_stall;

	sfp_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.tx_data     (tx_data),
		.error_raised(error_raised),
		.rx_level    (rx_level),
		.tx_level    (tx_level),
		.busy_req    (busy_req),
		.cfg         (cfg),
		.free        (free),
		.emit        (emit),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (free && emit) begin
			res_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign kind             = res_q.kind;
	assign buffer_index     = res_q.buffer_index;
	assign tx_byte          = res_q.tx_byte;
	assign status           = res_q.status;
	assign enable_error_irq = res_q.enable_error_irq;
	assign enable_rx_irq    = res_q.enable_rx_irq;
	assign enable_tx_irq    = res_q.enable_tx_irq;
	assign done_res         = res_q.done_res;
	assign last             = res_q.last;
endmodule
